[hdl/fbe_pkg.sv]
`timescale 1ns / 1ps
package fbe_pkg;

  // Command codes on the input stream
  localparam logic [1:0] CMD_COEF = 2'd0;
  localparam logic [1:0] CMD_SAMP = 2'd1;
  localparam logic [1:0] CMD_COMP = 2'd2;

  // Boundary modes
  localparam logic [2:0] MODE_ASYM = 3'd0;
  localparam logic [2:0] MODE_ZERO = 3'd1;
  localparam logic [2:0] MODE_HMIR = 3'd2;
  localparam logic [2:0] MODE_WMIR = 3'd3;
  localparam logic [2:0] MODE_PER  = 3'd4;

  // Register indexes
  localparam logic [1:0] REG_MODE   = 2'd0;
  localparam logic [1:0] REG_LENGTH = 2'd1;
  localparam logic [1:0] REG_TAPS   = 2'd2;
  localparam logic [1:0] REG_ORIGIN = 2'd3;

  typedef struct packed {
    logic [2:0]  mode;
    logic [12:0] n;       // signal length, already clamped to capacity
    logic [6:0]  taps;    // tap count, already clamped to capacity
    logic [5:0]  origin;
  } cfg_t;

  typedef struct packed {
    logic [1:0]         kind;   // CMD_COEF, CMD_SAMP or CMD_COMP
    logic [11:0]        addr;   // tap index, sample index or output position
    logic signed [15:0] data;
  } entry_t;

endpackage

[hdl/fbe_front.sv]
`timescale 1ns / 1ps
module fbe_front #(
  parameter int MAX_SAMPLES = 4096,
  parameter int MAX_TAPS    = 64
) (
  input  logic           rst,
  input  fbe_pkg::cfg_t  cfg,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [55:0]    in_data,
  output logic           push,
  output fbe_pkg::entry_t push_entry,
  input  logic           q_full
);
  import fbe_pkg::*;

  logic [1:0]  cmd;
  logic [5:0]  tap_index;
  logic [11:0] position;
  logic        keep;

  assign cmd       = in_data[1:0];
  assign tap_index = in_data[7:2];
  assign position  = in_data[35:24];
  assign in_ready  = !q_full;

  // Drop everything that would have no effect and no result
  always_comb begin
    keep = 1'b0;
    push_entry.kind = cmd;
    push_entry.addr = position;
    push_entry.data = in_data[51:36];
    unique case (cmd)
      CMD_COEF: begin
        keep = 32'(tap_index) < 32'(MAX_TAPS);
        push_entry.addr = 12'(tap_index);
        push_entry.data = in_data[23:8];
      end
      CMD_SAMP: keep = 32'(position) < 32'(MAX_SAMPLES);
      CMD_COMP: keep = (cfg.mode <= MODE_PER) && (13'(position) < cfg.n);
      default:  keep = 1'b0;
    endcase
  end

  assign push = in_valid && in_ready && keep && !rst;

endmodule

[hdl/fbe_fifo.sv]
`timescale 1ns / 1ps
module fbe_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  fbe_pkg::entry_t push_entry,
  output logic            full,
  input  logic            pop,
  output logic            valid,
  output fbe_pkg::entry_t head
);
  import fbe_pkg::*;

  localparam int DEPTH = 4;

  entry_t     slots [DEPTH];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic [2:0] count;

  assign full  = count == 3'(DEPTH);
  assign valid = count != 3'd0;
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 2'd1;
      if (pop)  rd_ptr <= rd_ptr + 2'd1;
      count <= count + 3'(push) - 3'(pop);
    end
  end

endmodule

[hdl/fbe_back.sv]
`timescale 1ns / 1ps
module fbe_back #(
  parameter int MAX_SAMPLES = 4096,
  parameter int MAX_TAPS    = 64
) (
  input  logic            clk,
  input  logic            rst,
  input  fbe_pkg::cfg_t   cfg,
  input  logic            q_valid,
  input  fbe_pkg::entry_t q_head,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [47:0]     out_filtered,
  output logic [11:0]     out_pos
);
  import fbe_pkg::*;

  localparam int SA = (MAX_SAMPLES > 2) ? $clog2(MAX_SAMPLES) : 1;
  localparam int TA = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DIV   = 3'd1;
  localparam logic [2:0] S_MUL   = 3'd2;
  localparam logic [2:0] S_TAPS  = 3'd3;
  localparam logic [2:0] S_DRAIN = 3'd4;
  localparam logic [2:0] S_FIN   = 3'd5;

  logic [2:0] state;

  logic signed [15:0] smem [MAX_SAMPLES];
  logic signed [15:0] cmem [MAX_TAPS];
  logic signed [15:0] sdat;
  logic signed [15:0] cdat;
  logic [SA-1:0]      s_raddr;
  logic [TA-1:0]      c_raddr;

  logic [15:0]        period;
  logic [12:0]        dvd;      // dividend, shifted out msb first
  logic [15:0]        drem;
  logic [12:0]        dquo;
  logic [3:0]         dcnt;
  logic [16:0]        drem_sh;
  logic signed [15:0] first;
  logic signed [15:0] last;
  logic signed [16:0] diff;

  logic signed [15:0] idx;
  logic [16:0]        r;
  logic signed [33:0] off;
  logic [6:0]         tcnt;
  logic [1:0]         drn;
  logic [11:0]        pos;

  // tap mapping (stage A)
  logic [16:0]        map_addr;
  logic               map_zero;
  logic               map_anti;

  logic               v_b, v_c, v_d;
  logic               zero_b, anti_b;
  logic signed [33:0] off_b;
  logic signed [33:0] xval;
  logic signed [15:0] hval;
  logic signed [49:0] prod;
  logic [47:0]        acc;
  logic signed [33:0] x_next;

  logic start;
  assign start = (state == S_IDLE) && q_valid && (q_head.kind != CMD_COMP || !out_valid);
  assign pop = start;

  assign diff = 17'(last) - 17'(first);
  assign drem_sh = {drem, dvd[12]};

  always_comb begin
    map_addr = r;
    map_zero = 1'b0;
    map_anti = 1'b0;
    unique case (cfg.mode)
      MODE_ZERO: begin
        map_addr = 17'(unsigned'(idx));
        map_zero = idx[15] || (idx >= $signed({3'b000, cfg.n}));
      end
      MODE_WMIR, MODE_ASYM: begin
        if (r >= 17'(cfg.n)) begin
          map_addr = 17'(period) - r;
          map_anti = cfg.mode == MODE_ASYM;
        end
      end
      MODE_HMIR: begin
        if (r >= 17'(cfg.n)) map_addr = 17'(period) - 17'd1 - r;
      end
      default: map_addr = r;
    endcase
  end

  // sample read port
  always_comb begin
    priority if (state == S_DIV && dcnt == 4'd0) s_raddr = '0;
    else if (state == S_DIV) s_raddr = SA'(cfg.n - 13'd1);
    else s_raddr = SA'(map_addr);
  end
  assign c_raddr = TA'(tcnt);

  always_ff @(posedge clk) begin
    if (start && q_head.kind == CMD_SAMP) smem[SA'(q_head.addr)] <= q_head.data;
    sdat <= smem[s_raddr];
  end

  always_ff @(posedge clk) begin
    if (start && q_head.kind == CMD_COEF) cmem[TA'(q_head.addr)] <= q_head.data;
    cdat <= cmem[c_raddr];
  end

  always_comb begin
    if (anti_b) x_next = 34'(last) * 34'sd2 - 34'(sdat) + off_b;
    else x_next = 34'(sdat) + off_b;
    if (zero_b) x_next = '0;
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (start) begin
      pos <= q_head.addr;
      dvd <= 13'(q_head.addr) + 13'(cfg.origin);
      drem <= '0;
      dquo <= '0;
      idx <= 16'(q_head.addr) + 16'(cfg.origin);
      acc <= '0;
      if (cfg.n == 13'd1) period <= 16'd1;
      else begin
        unique case (cfg.mode)
          MODE_HMIR:            period <= {2'b00, cfg.n, 1'b0};
          MODE_WMIR, MODE_ASYM: period <= {2'b00, cfg.n - 13'd1, 1'b0};
          default:              period <= {3'b000, cfg.n};
        endcase
      end
    end
    if (state == S_DIV) begin
      dvd <= {dvd[11:0], 1'b0};
      if (drem_sh >= 17'(period)) begin
        drem <= 16'(drem_sh - 17'(period));
        dquo <= {dquo[11:0], 1'b1};
      end else begin
        drem <= 16'(drem_sh);
        dquo <= {dquo[11:0], 1'b0};
      end
      if (dcnt == 4'd1) first <= sdat;
      if (dcnt == 4'd2) last <= sdat;
    end
    if (state == S_MUL) begin
      r <= 17'(drem);
      off <= (cfg.mode == MODE_ASYM) ?
             34'($signed({1'b0, dquo})) * 34'(diff) * 34'sd2 : '0;
    end
    if (state == S_TAPS) begin
      idx <= idx - 16'sd1;
      if (r == '0) begin
        r <= 17'(period) - 17'd1;
        if (cfg.mode == MODE_ASYM) off <= off - 34'(diff) * 34'sd2;
      end else begin
        r <= r - 17'd1;
      end
    end
    zero_b <= map_zero;
    anti_b <= map_anti;
    off_b  <= map_anti ? off : off;
    xval   <= x_next;
    hval   <= cdat;
    prod   <= xval * hval;
    if (v_d) acc <= acc + prod[47:0];
    if (state == S_FIN) begin
      out_filtered <= acc;
      out_pos      <= pos;
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      dcnt <= '0;
      tcnt <= '0;
      drn <= '0;
      v_b <= 1'b0;
      v_c <= 1'b0;
      v_d <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v_b <= state == S_TAPS;
      v_c <= v_b;
      v_d <= v_c;
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          dcnt <= '0;
          if (start && q_head.kind == CMD_COMP) state <= S_DIV;
        end
        S_DIV: begin
          dcnt <= dcnt + 4'd1;
          if (dcnt == 4'd12) state <= S_MUL;
        end
        S_MUL: begin
          tcnt <= '0;
          drn <= '0;
          state <= (cfg.taps == 7'd0) ? S_DRAIN : S_TAPS;
        end
        S_TAPS: begin
          tcnt <= tcnt + 7'd1;
          if (tcnt == cfg.taps - 7'd1) state <= S_DRAIN;
        end
        S_DRAIN: begin
          drn <= drn + 2'd1;
          if (drn == 2'd2) state <= S_FIN;
        end
        S_FIN: begin
          out_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[hdl/fir_boundary_extension_filter.sv]
`timescale 1ns / 1ps
// FIR filter over a loaded signal with boundary extension. Coefficients and
// samples are written through the input stream into on-chip memories; a
// compute transfer returns one Q.14 output for the given position, or nothing
// when the position is at or past the signal length or the boundary mode is
// not a defined one. A compute is taken from the queue, then passes through
// the shift-and-subtract unit that folds the start index into the extension
// period, a step that scales the antisymmetric offset, the taps, one per cycle
// through the single sample memory read port and multiplier, and the drain of
// the multiply-accumulate pipeline. A four-entry queue lets the input side
// keep taking transfers meanwhile.
module fir_boundary_extension_filter #(
  parameter int MAX_SAMPLES = 4096,
  parameter int MAX_TAPS    = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,   // cmd, tap_index, coefficient, position, sample
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // filtered, out_position, zero pad
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import fbe_pkg::*;

  logic [2:0]  boundary_mode;
  logic [12:0] signal_length;
  logic [6:0]  tap_count;
  logic [5:0]  tap_origin;
  cfg_t        cfg;

  logic   push, q_full, q_valid, pop;
  entry_t push_entry, q_head;
  logic [47:0] filtered;
  logic [11:0] out_position;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      boundary_mode <= MODE_ZERO;
      signal_length <= 13'd1;
      tap_count     <= 7'd1;
      tap_origin    <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        REG_MODE:   boundary_mode <= pwdata[2:0];
        REG_LENGTH: signal_length <= pwdata[12:0];
        REG_TAPS:   tap_count     <= pwdata[6:0];
        REG_ORIGIN: tap_origin    <= pwdata[5:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_MODE:   prdata = 32'(boundary_mode);
      REG_LENGTH: prdata = 32'(signal_length);
      REG_TAPS:   prdata = 32'(tap_count);
      REG_ORIGIN: prdata = 32'(tap_origin);
      default:    prdata = '0;
    endcase
  end

  always_comb begin
    cfg.mode   = boundary_mode;
    cfg.origin = tap_origin;
    cfg.n      = (32'(signal_length) > 32'(MAX_SAMPLES)) ? 13'(MAX_SAMPLES) : signal_length;
    cfg.taps   = (32'(tap_count) > 32'(MAX_TAPS)) ? 7'(MAX_TAPS) : tap_count;
  end

  fbe_front #(.MAX_SAMPLES(MAX_SAMPLES), .MAX_TAPS(MAX_TAPS)) u_front (
    .rst, .cfg,
    .in_valid(s_tvalid), .in_ready(s_tready), .in_data(s_tdata),
    .push, .push_entry, .q_full
  );

  fbe_fifo u_fifo (
    .clk, .rst, .push, .push_entry, .full(q_full),
    .pop, .valid(q_valid), .head(q_head)
  );

  fbe_back #(.MAX_SAMPLES(MAX_SAMPLES), .MAX_TAPS(MAX_TAPS)) u_back (
    .clk, .rst, .cfg, .q_valid, .q_head, .pop,
    .out_valid(m_tvalid), .out_ready(m_tready),
    .out_filtered(filtered), .out_pos(out_position)
  );

  assign m_tdata = {4'd0, out_position, filtered};

endmodule

[hdl/fbe_checker.sv]
`timescale 1ns / 1ps
module fbe_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [63:0] m_tdata
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[63:60] == 4'd0)
    else $error("pad bits of result not zero");

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata))
    else $error("result changed while stalled");

endmodule

bind fir_boundary_extension_filter fbe_checker u_fbe_checker (
  .clk, .rst, .m_tvalid, .m_tready, .m_tdata
);
